// ===== src/txcat_pkg.sv =====
// txcat_pkg: shared types, character codes and register indexes for the
// text stream formatter. No dependencies.
`default_nettype none

package txcat_pkg;

    // Default width of the line counter in decimal digits
    localparam int NUMBER_DIGITS_DEF = 6;

    // Descriptor queue depth between front and back
    localparam int Q_DEPTH = 2;

    // Escape body: at most four bytes ("M-^X")
    localparam int BODY_MAX   = 4;
    localparam int BODY_CNT_W = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_FF     = 8'hFF;
    localparam logic [7:0] CTRL_LIMIT  = 8'h20;  // below this: control
    localparam logic [7:0] META_SPLIT  = 8'hA0;  // 128..159 get "M-^"
    localparam logic [7:0] CTRL_OFFSET = 8'h40;
    localparam logic [7:0] META_OFFSET = 8'h80;

    localparam logic [1:0] RUN_MAX = 2'd2;

    typedef struct packed {
        logic number_nonblank;
        logic show_ends;
        logic number_all;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // What the back end must write for one item (the line number travels
    // beside it, its width follows the digit count)
    typedef struct packed {
        logic                       num;
        logic                       dollar;
        logic [BODY_CNT_W-1:0]      body_cnt;
        logic [BODY_MAX-1:0][7:0]   body;
    } t_desc;

endpackage

`default_nettype wire

// ===== src/txcat_if.sv =====
// txcat interfaces: input byte stream, output byte stream, config writes.
// Depends on txcat_pkg.
`default_nettype none

interface txcat_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       file_first;
    modport source (output valid, output in_byte, output file_first, input ready);
    modport sink   (input valid, input in_byte, input file_first, output ready);
endinterface

interface txcat_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface txcat_cfg_if import txcat_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/txcat_front.sv =====
// txcat_front: takes requests, tracks line state and counter, classifies each
// byte into a descriptor. Depends on txcat_pkg.
`default_nettype none

module txcat_front
    import txcat_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_in_byte,
    input  wire logic                         i_file_first,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic                         i_cfg_data,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output t_desc                             o_desc,
    output logic [NUMBER_DIGITS-1:0][3:0]     o_bcd
);

    t_cfg                            r_cfg;
    logic [7:0]                      r_prev;
    logic [NUMBER_DIGITS-1:0][3:0]   r_bcd;
    logic [1:0]                      r_run;

    logic                            accept;
    logic                            after_nl;
    logic [1:0]                      run0;
    logic [1:0]                      n_run;
    logic                            sq_sup;
    logic                            do_num;
    logic                            all_nines;
    logic                            carry;
    logic [NUMBER_DIGITS-1:0][3:0]   bcd_inc;
    logic [NUMBER_DIGITS-1:0][3:0]   n_bcd;
    t_desc                           desc;
    logic                            is_ctrl;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_q_full;

    always_comb begin
        after_nl = (r_prev == CH_LF);
        run0     = i_file_first ? 2'd0 : r_run;
        n_run    = run0;
        sq_sup   = 1'b0;
        if (r_cfg.squeeze_blank) begin
            if (i_in_byte == CH_LF && after_nl) begin
                if (run0 < RUN_MAX) n_run = run0 + 2'd1;
                sq_sup = (n_run >= RUN_MAX);
            end else if (i_in_byte != CH_LF && after_nl && run0 != 2'd0) begin
                n_run = 2'd0;
            end
        end

        do_num = (r_cfg.number_all || r_cfg.number_nonblank) && !sq_sup && after_nl
                 && (r_cfg.number_all || i_in_byte != CH_LF);

        // saturating decimal increment
        all_nines = 1'b1;
        carry     = 1'b1;
        bcd_inc   = r_bcd;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (r_bcd[i] != 4'd9) all_nines = 1'b0;
            if (carry) begin
                if (r_bcd[i] >= 4'd9) begin
                    bcd_inc[i] = 4'd0;
                end else begin
                    bcd_inc[i] = r_bcd[i] + 4'd1;
                    carry      = 1'b0;
                end
            end
        end
        n_bcd = (do_num && !all_nines) ? bcd_inc : r_bcd;

        is_ctrl = (i_in_byte < CTRL_LIMIT) && i_in_byte != CH_TAB && i_in_byte != CH_LF;

        desc.num      = do_num;
        desc.dollar   = r_cfg.show_ends && i_in_byte == CH_LF
                        && (!r_cfg.squeeze_blank || n_run < RUN_MAX);
        desc.body     = '0;
        desc.body_cnt = '0;
        if (r_cfg.show_tabs && i_in_byte == CH_TAB) begin
            desc.body[0]  = CH_CARET;
            desc.body[1]  = CH_I;
            desc.body_cnt = BODY_CNT_W'(2);
        end else if (r_cfg.show_nonprinting && is_ctrl) begin
            desc.body[0]  = CH_CARET;
            desc.body[1]  = i_in_byte + CTRL_OFFSET;
            desc.body_cnt = BODY_CNT_W'(2);
        end else if (r_cfg.show_nonprinting && i_in_byte > CH_DEL
                     && i_in_byte < META_SPLIT) begin
            desc.body[0]  = CH_M;
            desc.body[1]  = CH_DASH;
            desc.body[2]  = CH_CARET;
            desc.body[3]  = i_in_byte - CTRL_OFFSET;
            desc.body_cnt = BODY_CNT_W'(4);
        end else if (r_cfg.show_nonprinting && i_in_byte == CH_FF) begin
            desc.body[0]  = CH_M;
            desc.body[1]  = CH_DASH;
            desc.body[2]  = CH_CARET;
            desc.body[3]  = CH_QMARK;
            desc.body_cnt = BODY_CNT_W'(4);
        end else if (r_cfg.show_nonprinting && i_in_byte >= META_SPLIT) begin
            desc.body[0]  = CH_M;
            desc.body[1]  = CH_DASH;
            desc.body[2]  = i_in_byte - META_OFFSET;
            desc.body_cnt = BODY_CNT_W'(3);
        end else if (r_cfg.show_nonprinting && i_in_byte == CH_DEL) begin
            desc.body[0]  = CH_CARET;
            desc.body[1]  = CH_QMARK;
            desc.body_cnt = BODY_CNT_W'(2);
        end else if (!sq_sup) begin
            desc.body[0]  = i_in_byte;
            desc.body_cnt = BODY_CNT_W'(1);
        end
    end

    // a squeezed newline writes nothing and never reaches the queue
    assign o_push = accept && (desc.num || desc.dollar || desc.body_cnt != '0);
    assign o_desc = desc;
    assign o_bcd  = n_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= '0;
            r_prev <= CH_LF;
            r_bcd  <= '0;
            r_run  <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data;
                    CFG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data;
                    CFG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data;
                    CFG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data;
                    CFG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data;
                    CFG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_prev <= i_in_byte;
                r_run  <= n_run;
                r_bcd  <= n_bcd;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/txcat_queue.sv =====
// txcat_queue: short descriptor queue between front and back end.
// Depends on txcat_pkg.
`default_nettype none

module txcat_queue
    import txcat_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire t_desc                         i_desc,
    input  wire logic [NUMBER_DIGITS-1:0][3:0] i_bcd,
    output logic                               o_full,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output t_desc                              o_desc,
    output logic [NUMBER_DIGITS-1:0][3:0]      o_bcd
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_desc                         r_desc [Q_DEPTH];
    logic [NUMBER_DIGITS-1:0][3:0] r_bcd  [Q_DEPTH];
    logic [PTR_W-1:0]              r_wptr;
    logic [PTR_W-1:0]              r_rptr;
    logic [CNT_W-1:0]              r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_desc[r_rptr];
    assign o_bcd   = r_bcd[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_desc[r_wptr] <= i_desc;
            r_bcd[r_wptr]  <= i_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= ptr_inc(r_wptr);
            if (i_pop)  r_rptr <= ptr_inc(r_rptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/txcat_back.sv =====
// txcat_back: walks the head descriptor one output byte per cycle, while the
// output is not stalled, into a registered output stage. Depends on txcat_pkg.
`default_nettype none

module txcat_back
    import txcat_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_head_valid,
    input  wire t_desc                         i_head,
    input  wire logic [NUMBER_DIGITS-1:0][3:0] i_head_bcd,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [7:0]                         o_out_byte,
    output logic                               o_out_last
);

    // slots: digits, tab, dollar, body bytes
    localparam int POS_TAB  = NUMBER_DIGITS;
    localparam int POS_DOL  = NUMBER_DIGITS + 1;
    localparam int POS_BODY = NUMBER_DIGITS + 2;
    localparam int POS_W    = $clog2(NUMBER_DIGITS + 2 + BODY_MAX);

    logic              r_busy;
    logic [POS_W-1:0]  r_pos;
    logic              r_lead;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic              load;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  n_pos;
    logic [POS_W-1:0]  pos_off;
    logic [1:0]        bidx;
    logic [3:0]        digit;
    logic              lead;
    logic [7:0]        cur_byte;
    logic              cur_last;

    assign load = i_head_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        if (r_busy)                cur_pos = r_pos;
        else if (i_head.num)       cur_pos = '0;
        else if (i_head.dollar)    cur_pos = POS_W'(POS_DOL);
        else                       cur_pos = POS_W'(POS_BODY);

        pos_off = cur_pos - POS_W'(POS_BODY);
        bidx    = pos_off[1:0];

        digit = 4'd0;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (cur_pos == POS_W'(k)) digit = i_head_bcd[NUMBER_DIGITS - 1 - k];
        end
        // units digit is always printed
        lead = (r_busy ? r_lead : 1'b1) && digit == 4'd0
               && cur_pos != POS_W'(NUMBER_DIGITS - 1);

        if (cur_pos < POS_W'(POS_TAB)) begin
            cur_byte = lead ? CH_SPACE : (CH_ZERO + {4'd0, digit});
            cur_last = 1'b0;
            n_pos    = cur_pos + POS_W'(1);
        end else if (cur_pos == POS_W'(POS_TAB)) begin
            cur_byte = CH_TAB;
            cur_last = !i_head.dollar && i_head.body_cnt == '0;
            n_pos    = i_head.dollar ? POS_W'(POS_DOL) : POS_W'(POS_BODY);
        end else if (cur_pos == POS_W'(POS_DOL)) begin
            cur_byte = CH_DOLLAR;
            cur_last = (i_head.body_cnt == '0);
            n_pos    = POS_W'(POS_BODY);
        end else begin
            cur_byte = i_head.body[bidx];
            cur_last = ({1'b0, bidx} + BODY_CNT_W'(1)) == i_head.body_cnt;
            n_pos    = cur_pos + POS_W'(1);
        end
    end

    assign o_pop       = load && cur_last;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
            r_pos      <= n_pos;
            r_lead     <= lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_busy      <= !cur_last;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== src/text_stream_cat_formatter.sv =====
// Text stream formatter top: line numbering, end marks, tab and nonprinting
// escapes, blank-line squeeze. A taken request that writes bytes enters the
// descriptor queue, and the back end registers its output bytes from the queue head.
// Throughput: one request per cycle while the 2-deep queue has room; the back end
// writes one byte per cycle while the output is not stalled, and an item yields
// 1 to NUMBER_DIGITS+5 bytes. Synchronous active-low reset restores defaults at once.
// Depends on txcat_pkg, txcat_if, txcat_front, txcat_queue, txcat_back.
`default_nettype none

module text_stream_cat_formatter
    import txcat_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    txcat_in_if.sink      i_in,
    txcat_out_if.source   o_out,
    txcat_cfg_if.sink     i_cfg
);

    // Front: holds config, previous byte, blank run and the line counter;
    // each request becomes a descriptor (number?, dollar?, up to 4 body bytes).
    // Requests that write nothing (squeezed newlines) are dropped here.
    logic                          w_q_full;
    logic                          w_push;
    t_desc                         w_desc;
    logic [NUMBER_DIGITS-1:0][3:0] w_bcd;

    // Queue to back end
    logic                          w_pop;
    logic                          w_head_valid;
    t_desc                         w_head;
    logic [NUMBER_DIGITS-1:0][3:0] w_head_bcd;

    logic                          w_in_ready;
    logic                          w_cfg_ready;
    logic                          w_out_valid;
    logic [7:0]                    w_out_byte;
    logic                          w_out_last;

    assign i_in.ready     = w_in_ready;
    assign i_cfg.ready    = w_cfg_ready;
    assign o_out.valid    = w_out_valid;
    assign o_out.out_byte = w_out_byte;
    assign o_out.last     = w_out_last;

    txcat_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (w_in_ready),
        .i_in_byte    (i_in.in_byte),
        .i_file_first (i_in.file_first),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (w_cfg_ready),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_desc       (w_desc),
        .o_bcd        (w_bcd)
    );

    // Descriptor queue decouples intake from the byte serialiser
    txcat_queue #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_bcd   (w_bcd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_desc  (w_head),
        .o_bcd   (w_head_bcd)
    );

    // Back: one byte per cycle, while the output is not stalled, into the output
    // register; pops the head on the byte flagged last
    txcat_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .i_head_bcd   (w_head_bcd),
        .o_pop        (w_pop),
        .o_out_valid  (w_out_valid),
        .i_out_ready  (o_out.ready),
        .o_out_byte   (w_out_byte),
        .o_out_last   (w_out_last)
    );

endmodule

`default_nettype wire

// ===== src/txcat_checker.sv =====
// txcat_checker: port-level assertions for the formatter, bound to the top.
// Depends on text_stream_cat_formatter.
`default_nettype none

module txcat_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_out_last))
        else $error("output changed while stalled");

    // reset empties the output stage
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // intake only backs up when the output stage holds a result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

    // a stall with a waiting request is never released by the block itself
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready && !i_out_ready |=> !i_in_ready)
        else $error("input ready rose without output progress");

endmodule

bind text_stream_cat_formatter txcat_checker u_txcat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

`default_nettype wire

// ===== dv/tb_text_stream_cat_formatter.sv =====
// Self-checking testbench for text_stream_cat_formatter: drives byte requests,
// predicts the formatted output bytes and compares them at the output stream.
// Depends on txcat_pkg, txcat_if and the formatter RTL.
`default_nettype none

module tb_text_stream_cat_formatter;
    import txcat_pkg::*;

    localparam int          DIGITS       = NUMBER_DIGITS_DEF;
    localparam int          IDLE_PCT     = 34;      // chance of a gap or stall per cycle
    localparam int          DRAIN_CYCLES = 16;      // quiet time once nothing is expected
    localparam int unsigned CYCLE_LIMIT  = 300000;  // far beyond the slowest correct run
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 55;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Settings vector, bit i goes to register index i
    localparam logic [5:0] SET_NONE      = 6'b000000;
    localparam logic [5:0] SET_ALL       = 6'b111111;
    localparam logic [5:0] SET_NUMBERING = 6'b000011;  // nonblank numbering plus end marks

    typedef struct {
        logic [7:0] ch;
        logic       first;
    } text_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } formatted_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    txcat_in_if  in_bus ();
    txcat_out_if out_bus ();
    txcat_cfg_if cfg_bus ();

    text_stream_cat_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // Requests waiting to be driven, and output bytes still owed by the block
    text_item_t  pending_chars[$];
    formatted_t  expected_bytes[$];

    // Shadow of the formatter's registers and state
    t_cfg               cfg_shadow;
    logic [7:0]         prev_char;
    logic [4*DIGITS-1:0] line_count_bcd;
    logic [1:0]         blank_lines;

    logic        steady;        // no gaps, no stalls while set
    int unsigned fail_count;
    int unsigned cycle_count;

    // ------------------------------------------------------------------
    // Prediction: the bytes one accepted request must produce, in order
    // ------------------------------------------------------------------
    task automatic format_byte(input logic [7:0] c, input logic first);
        logic [7:0] burst[$];
        logic       after_lf;
        logic       drop;
        logic       lead;
        logic       saturated;
        logic       carry;
        logic [3:0] digit;
        formatted_t res;
        int         i;

        after_lf = (prev_char == CH_LF);
        drop     = 1'b0;

        // a new file forgets any blank-line run
        if (first) blank_lines = '0;

        // run counting only happens in squeeze mode; otherwise it is frozen
        if (cfg_shadow.squeeze_blank) begin
            if (c == CH_LF && after_lf) begin
                if (blank_lines < RUN_MAX) blank_lines = blank_lines + 2'd1;
                drop = (blank_lines >= RUN_MAX);
            end else if (c != CH_LF && after_lf && blank_lines != '0) begin
                blank_lines = '0;
            end
        end

        // line number at line start; number_all wins over nonblank mode
        if ((cfg_shadow.number_all || cfg_shadow.number_nonblank) && !drop && after_lf &&
            (cfg_shadow.number_all || c != CH_LF)) begin
            // BCD count, held at all nines
            saturated = 1'b1;
            for (i = 0; i < DIGITS; i++)
                if (line_count_bcd[4*i +: 4] != 4'd9) saturated = 1'b0;
            if (!saturated) begin
                carry = 1'b1;
                for (i = 0; i < DIGITS; i++) begin
                    if (carry) begin
                        if (line_count_bcd[4*i +: 4] >= 4'd9) begin
                            line_count_bcd[4*i +: 4] = 4'd0;
                        end else begin
                            line_count_bcd[4*i +: 4] = line_count_bcd[4*i +: 4] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
            // right aligned, leading zeroes shown as spaces, units always printed
            lead = 1'b1;
            for (i = DIGITS - 1; i >= 0; i--) begin
                digit = line_count_bcd[4*i +: 4];
                if (digit != 4'd0 || i == 0) lead = 1'b0;
                burst.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, digit});
            end
            burst.push_back(CH_TAB);
        end

        // end mark, not on a newline swallowed by the squeeze
        if (cfg_shadow.show_ends && c == CH_LF &&
            (!cfg_shadow.squeeze_blank || blank_lines < RUN_MAX))
            burst.push_back(CH_DOLLAR);

        if (cfg_shadow.show_tabs && c == CH_TAB) begin
            burst.push_back(CH_CARET);
            burst.push_back(CH_I);
            drop = 1'b1;
        end

        if (cfg_shadow.show_nonprinting) begin
            if ((c < CTRL_LIMIT && c != CH_TAB && c != CH_LF) || c >= CH_DEL) drop = 1'b1;
            if (c < CTRL_LIMIT && c != CH_TAB && c != CH_LF) begin
                burst.push_back(CH_CARET);
                burst.push_back(c + CTRL_OFFSET);
            end else if (c > CH_DEL && c < META_SPLIT) begin
                burst.push_back(CH_M);
                burst.push_back(CH_DASH);
                burst.push_back(CH_CARET);
                burst.push_back(c - CTRL_OFFSET);
            end else if (c == CH_FF) begin
                // 0xFF is plain data here, shown as M-^?
                burst.push_back(CH_M);
                burst.push_back(CH_DASH);
                burst.push_back(CH_CARET);
                burst.push_back(CH_QMARK);
            end else if (c >= META_SPLIT) begin
                burst.push_back(CH_M);
                burst.push_back(CH_DASH);
                burst.push_back(c - META_OFFSET);
            end else if (c == CH_DEL) begin
                burst.push_back(CH_CARET);
                burst.push_back(CH_QMARK);
            end
        end

        if (!drop) burst.push_back(c);
        prev_char = c;

        // a dropped newline owes nothing
        for (i = 0; i < burst.size(); i++) begin
            res.out_byte = burst[i];
            res.last     = (i == burst.size() - 1);
            expected_bytes.push_back(res);
        end
    endtask

    task automatic note_mismatch(input string what, input formatted_t exp_res,
                                 input formatted_t got_res);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected byte %02h last %b, got byte %02h last %b",
                     what, exp_res.out_byte, exp_res.last, got_res.out_byte, got_res.last);
    endtask

    // ------------------------------------------------------------------
    // Input driver: accepted requests feed the predictor, gaps at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : char_driver
        text_item_t item;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                format_byte(in_bus.in_byte, in_bus.file_first);
            // hold a request until it is taken; only then load the next one
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_chars.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    item = pending_chars.pop_front();
                    in_bus.valid      <= 1'b1;
                    in_bus.in_byte    <= item.ch;
                    in_bus.file_first <= item.first;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: random back-pressure, in-order compare
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_monitor
        formatted_t got_res;
        formatted_t exp_res;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_res.out_byte = out_bus.out_byte;
                got_res.last     = out_bus.last;
                if (expected_bytes.size() == 0) begin
                    exp_res.out_byte = 'x;
                    exp_res.last     = 'x;
                    note_mismatch("unexpected output", exp_res, got_res);
                end else begin
                    exp_res = expected_bytes.pop_front();
                    if (got_res.out_byte !== exp_res.out_byte || got_res.last !== exp_res.last)
                        note_mismatch("output mismatch", exp_res, got_res);
                end
            end
            out_bus.ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] ch, input logic first);
        text_item_t item;
        item.ch    = ch;
        item.first = first;
        pending_chars.push_back(item);
    endtask

    // one register write; the shadow follows on the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_NUMBER_NONBLANK:  cfg_shadow.number_nonblank  = val;
            CFG_SHOW_ENDS:        cfg_shadow.show_ends        = val;
            CFG_NUMBER_ALL:       cfg_shadow.number_all       = val;
            CFG_SQUEEZE_BLANK:    cfg_shadow.squeeze_blank    = val;
            CFG_SHOW_TABS:        cfg_shadow.show_tabs        = val;
            CFG_SHOW_NONPRINTING: cfg_shadow.show_nonprinting = val;
            default: ;  // unused index, ignored by the block
        endcase
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [5:0] bits);
        write_reg(CFG_NUMBER_NONBLANK,  bits[CFG_NUMBER_NONBLANK]);
        write_reg(CFG_SHOW_ENDS,        bits[CFG_SHOW_ENDS]);
        write_reg(CFG_NUMBER_ALL,       bits[CFG_NUMBER_ALL]);
        write_reg(CFG_SQUEEZE_BLANK,    bits[CFG_SQUEEZE_BLANK]);
        write_reg(CFG_SHOW_TABS,        bits[CFG_SHOW_TABS]);
        write_reg(CFG_SHOW_NONPRINTING, bits[CFG_SHOW_NONPRINTING]);
    endtask

    // sender holds off until every owed byte is out, then a quiet spell
    // so a trailing dropped newline is finished too
    task automatic settle();
        while (pending_chars.size() != 0 || in_bus.valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed text: lines of printable bytes, blank runs and
    // file starts, with tabs, controls and high bytes mixed in.
    task automatic queue_random_text(input int count);
        int   stop_at;
        int   roll;
        int   len;
        int   k;
        logic next_first;
        logic [7:0] ch;
        stop_at    = pending_chars.size() + count;
        next_first = 1'b0;
        while (pending_chars.size() < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                repeat ($urandom_range(4, 1)) begin
                    queue_char(CH_LF, next_first);
                    next_first = 1'b0;
                end
            end else if (roll < 20) begin
                next_first = 1'b1;
            end else begin
                len = $urandom_range(10);
                for (k = 0; k < len; k++) begin
                    roll = $urandom_range(99);
                    if (roll < 68)      ch = 8'($urandom_range(126, 32));
                    else if (roll < 80) ch = CH_TAB;
                    else                ch = 8'($urandom_range(255));
                    queue_char(ch, next_first);
                    next_first = 1'b0;
                end
                queue_char(CH_LF, next_first);
                next_first = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int p;

        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.in_byte     = '0;
        in_bus.file_first  = 1'b0;
        out_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_NUMBER_NONBLANK;
        cfg_bus.data       = 1'b0;
        steady             = 1'b0;
        fail_count         = 0;
        cycle_count        = 0;
        cfg_shadow         = '0;
        prev_char          = CH_LF;
        line_count_bcd     = '0;
        blank_lines        = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, every mode on: squeeze of a blank run, both numbering
        // modes at once, end marks, each escape class, 0xFF as data, and a
        // file start on a blank line.
        apply_settings(SET_ALL);
        queue_char(CH_LF, 1'b1);
        queue_char(CH_LF, 1'b0);
        queue_char(CH_LF, 1'b0);
        queue_char(CH_LF, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'h1F, 1'b0);
        queue_char(CH_TAB, 1'b0);
        queue_char(CH_DEL, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char(8'h9F, 1'b0);
        queue_char(META_SPLIT, 1'b0);
        queue_char(8'hFE, 1'b0);
        queue_char(CH_FF, 1'b0);
        queue_char(8'h41, 1'b0);
        queue_char(CH_LF, 1'b0);
        queue_char(CH_LF, 1'b1);
        settle();

        // Directed, nonblank numbering with squeeze off: blank run frozen,
        // raw tab, raw 0xFF and raw control byte pass through
        apply_settings(SET_NUMBERING);
        write_reg(CFG_UNUSED, 1'b1);  // must change nothing
        queue_char(CH_LF, 1'b0);
        queue_char(8'h61, 1'b0);
        queue_char(CH_TAB, 1'b0);
        queue_char(CH_FF, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(CH_LF, 1'b0);
        queue_char(CH_LF, 1'b0);
        settle();

        // Random text under a spread of settings, extremes first; one phase
        // runs with no gaps and no stalls at all
        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)      apply_settings(SET_NONE);
            else if (p == 1) apply_settings(SET_ALL);
            else             apply_settings(6'($urandom_range(63)));
            steady = (p == 4);
            queue_random_text(PHASE_ITEMS);
            settle();
            steady = 1'b0;
        end

        if (fail_count == 0 && expected_bytes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== text_stream_cat_formatter.f =====
src/txcat_pkg.sv
src/txcat_if.sv
src/txcat_front.sv
src/txcat_queue.sv
src/txcat_back.sv
src/text_stream_cat_formatter.sv
src/txcat_checker.sv
dv/tb_text_stream_cat_formatter.sv
